### rtl/core/satlb_pkg.sv
// ---------------------------------------------------------------------------
// satlb_pkg
// Shared types, widths and helpers for the set-associative TLB with random
// replacement.
// ---------------------------------------------------------------------------
package satlb_pkg;

    localparam int VADDR_W   = 32;
    localparam int PAGE_BITS = 12;
    localparam int VPN_W     = 20;
    localparam int PPN_W     = 20;
    localparam int LFSR_W    = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam int DEF_SETS = 8;
    localparam int DEF_WAYS = 4;

    // Request codes carried in req_type.
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    // One way of a set as it is stored in the entry memory.
    typedef struct packed {
        logic             valid;
        logic [VPN_W-1:0] tag;
        logic [PPN_W-1:0] ppn;
    } way_t;

    // Fibonacci LFSR, taps 16, 14, 13, 11, shifting right.
    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage

### rtl/core/satlb_if.sv
// ---------------------------------------------------------------------------
// satlb_if
// Valid/ready channels for TLB requests and responses.
// ---------------------------------------------------------------------------
interface satlb_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [satlb_pkg::VADDR_W-1:0] vaddr;
    logic [satlb_pkg::PPN_W-1:0]   new_ppn;

    modport source (output valid, output req_type, output vaddr, output new_ppn,
                    input ready);
    modport sink   (input valid, input req_type, input vaddr, input new_ppn,
                    output ready);
endinterface

interface satlb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [satlb_pkg::PPN_W-1:0] ppn_out;

    modport source (output valid, output hit, output ppn_out, input ready);
    modport sink   (input valid, input hit, input ppn_out, output ready);
endinterface

### rtl/core/satlb_ram.sv
// ---------------------------------------------------------------------------
// satlb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module satlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/satlb_cmod.sv
// ---------------------------------------------------------------------------
// satlb_cmod
// Remainder by a constant divisor in two registered steps: quotient by a
// reciprocal multiply, then the remainder by multiply and subtract.
// ---------------------------------------------------------------------------
module satlb_cmod #(
    parameter int IN_W    = 20,
    parameter int DIVISOR = 8,
    parameter int OUT_W   = 3
) (
    input  logic             clk,
    input  logic [IN_W-1:0]  din,
    output logic [OUT_W-1:0] rem
);

    // A shift of IN_W plus clog2(DIVISOR) plus one keeps the quotient exact.
    localparam int SH = IN_W + $clog2(DIVISOR) + 1;
    localparam int RW = SH + 1;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

    logic [IN_W+RW-1:0] prod;
    logic [IN_W-1:0]    quot_reg;
    logic [IN_W-1:0]    rem_full;
    logic [OUT_W-1:0]   rem_reg;

    assign prod     = (IN_W+RW)'(din) * (IN_W+RW)'(RECIP);
    assign rem_full = din - IN_W'(quot_reg * DIV_C);

    always_ff @(posedge clk)
    begin
        quot_reg <= prod[SH +: IN_W];
        rem_reg  <= rem_full[OUT_W-1:0];
    end

    assign rem = rem_reg;

endmodule

### rtl/core/set_assoc_tlb_random_replace_core.sv
// ---------------------------------------------------------------------------
// set_assoc_tlb_random_replace_core
// Set-associative TLB with LFSR-driven random replacement.
// ---------------------------------------------------------------------------
// Each request beat is a lookup or a fill and produces exactly one response
// beat. The virtual page number is vaddr[31:12]; the set is the page number
// modulo SETS and the full page number is kept as the tag. A lookup reports
// the lowest-numbered valid way whose tag matches, with its physical page
// number; a miss and every fill answer hit = 0 and ppn_out = 0. A fill first
// steps a 16-bit LFSR (seed 0xACE1) and overwrites way (LFSR mod WAYS) of the
// set without looking for an existing copy of the page. A request passes
// through S_MUL and S_SUB for the set index and the victim way (remainder
// by a constant through a reciprocal multiply), S_READ for the read of the
// set's row from the entry memory, and S_EVAL to compare the ways and, on a
// fill, write the row back; S_EVAL holds while a response waits unaccepted.
// Requests are taken one at a time, and the request side is ready again in
// the cycle after the response is loaded. The entry memory holds one row
// per set; a per-set valid flop, cleared by reset, marks rows that have
// been written, so the block is usable right after reset with no clearing
// pass.
// ---------------------------------------------------------------------------
module set_assoc_tlb_random_replace_core #(
    parameter int SETS = satlb_pkg::DEF_SETS,
    parameter int WAYS = satlb_pkg::DEF_WAYS
) (
    input  logic        clk,
    input  logic        rst_n,
    satlb_req_if.sink   req,
    satlb_rsp_if.source rsp
);

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W   = WAYS * $bits(satlb_pkg::way_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_READ,
        S_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Request held for the duration of its processing.
    logic                          is_fill_reg;
    logic [satlb_pkg::VPN_W-1:0]   vpn_reg;
    logic [satlb_pkg::PPN_W-1:0]   new_ppn_reg;
    logic [satlb_pkg::LFSR_W-1:0]  lfsr_reg;

    // One flop per set: the row has been written since reset.
    logic [SETS-1:0]               row_valid_reg;
    logic                          row_ok_reg;

    // Response output register.
    logic                          rsp_valid_reg;
    logic                          hit_reg;
    logic [satlb_pkg::PPN_W-1:0]   ppn_reg;

    logic [SET_W-1:0]              set_idx;
    logic [WAY_W-1:0]              victim;
    logic                          accept;
    logic                          slot_free;
    logic                          finish;

    satlb_pkg::way_t [WAYS-1:0]    rd_row;
    satlb_pkg::way_t [WAYS-1:0]    eff_row;
    satlb_pkg::way_t [WAYS-1:0]    wr_row;
    logic [ROW_W-1:0]              ram_rdata;
    logic                          ram_we;
    logic                          lk_hit;
    logic [satlb_pkg::PPN_W-1:0]   lk_ppn;

    // Set index and victim way are remainders by constants, worked out in
    // S_MUL and S_SUB from the held page number and already-stepped LFSR.
    satlb_cmod #(
        .IN_W    (satlb_pkg::VPN_W),
        .DIVISOR (SETS),
        .OUT_W   (SET_W)
    ) u_set_mod (
        .clk (clk),
        .din (vpn_reg),
        .rem (set_idx)
    );

    satlb_cmod #(
        .IN_W    (satlb_pkg::LFSR_W),
        .DIVISOR (WAYS),
        .OUT_W   (WAY_W)
    ) u_way_mod (
        .clk (clk),
        .din (lfsr_reg),
        .rem (victim)
    );

    satlb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_idx),
        .wdata (wr_row),
        .re    (state_reg == S_READ),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    assign rd_row    = ram_rdata;
    assign accept    = req.valid && (state_reg == S_IDLE);
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign finish    = (state_reg == S_EVAL) && slot_free;
    assign ram_we    = finish && is_fill_reg;

    // Way compare and write-back row. A row never written since reset reads
    // as all ways invalid, whatever the memory holds.
    always_comb
    begin
        eff_row = rd_row;
        lk_hit  = 1'b0;
        lk_ppn  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!row_ok_reg)
            begin
                eff_row[w].valid = 1'b0;
            end
        end
        // Scan downward so the lowest matching way wins.
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (eff_row[w].valid && (eff_row[w].tag == vpn_reg))
            begin
                lk_hit = 1'b1;
                lk_ppn = eff_row[w].ppn;
            end
        end
        wr_row                = eff_row;
        wr_row[victim].valid  = 1'b1;
        wr_row[victim].tag    = vpn_reg;
        wr_row[victim].ppn    = new_ppn_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_SUB;
            S_SUB:  state_next = S_READ;
            S_READ: state_next = S_EVAL;
            S_EVAL:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            is_fill_reg   <= 1'b0;
            vpn_reg       <= '0;
            new_ppn_reg   <= '0;
            lfsr_reg      <= satlb_pkg::LFSR_SEED;
            row_valid_reg <= '0;
            row_ok_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            ppn_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                is_fill_reg <= (req.req_type == satlb_pkg::REQ_FILL);
                vpn_reg     <= req.vaddr[satlb_pkg::PAGE_BITS +: satlb_pkg::VPN_W];
                new_ppn_reg <= req.new_ppn;
                // Only fills step the replacement LFSR.
                if (req.req_type == satlb_pkg::REQ_FILL)
                begin
                    lfsr_reg <= satlb_pkg::lfsr_advance(lfsr_reg);
                end
            end

            if (state_reg == S_READ)
            begin
                row_ok_reg <= row_valid_reg[set_idx];
            end

            if (ram_we)
            begin
                row_valid_reg[set_idx] <= 1'b1;
            end

            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
                hit_reg       <= is_fill_reg ? 1'b0 : lk_hit;
                ppn_reg       <= is_fill_reg ? '0 : lk_ppn;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.hit     = hit_reg;
    assign rsp.ppn_out = ppn_reg;

endmodule

### tb/sv/tb_set_assoc_tlb_random_replace_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_set_assoc_tlb_random_replace_core
// Self-checking bench for the set-associative TLB with random replacement.
// It feeds lookup and fill beats through the request channel and keeps a
// shadow copy of the entry array and the victim LFSR. Each accepted
// response beat is compared with the oldest predicted translation. Both
// channel sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_set_assoc_tlb_random_replace_core;

    import satlb_pkg::*;

    // The block is built with its default geometry, so the shadow copy uses
    // the same numbers.
    localparam int NUM_SETS    = DEF_SETS;
    localparam int NUM_WAYS    = DEF_WAYS;
    localparam int NUM_ENTRIES = NUM_SETS * NUM_WAYS;

    // Pages that the random part keeps coming back to. Five pages per set
    // against four ways means that lookups hit often and evictions still
    // happen.
    localparam int POOL_SIZE    = 40;
    localparam int RANDOM_BEATS = 800;

    // The block takes one request at a time, so a short wait after the
    // last response is enough to catch a stray extra beat.
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic               req_type;
        logic [VADDR_W-1:0] vaddr;
        logic [PPN_W-1:0]   new_ppn;
    } tlb_req_t;

    typedef struct packed {
        logic             hit;
        logic [PPN_W-1:0] ppn;
    } tlb_rsp_t;

    logic clk;
    logic rst_n;

    satlb_req_if req_ch ();
    satlb_rsp_if rsp_ch ();

    set_assoc_tlb_random_replace_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Request beats waiting to be driven, and translations predicted for
    // accepted requests but not yet seen on the response channel.
    tlb_req_t pending_reqs [$];
    tlb_rsp_t expected_rsps [$];

    // Shadow copy of the block's entry array and victim LFSR. Entry index is
    // set * NUM_WAYS + way, the same layout the lookup order depends on.
    logic              shadow_valid [NUM_ENTRIES];
    logic [VPN_W-1:0]  shadow_tag   [NUM_ENTRIES];
    logic [PPN_W-1:0]  shadow_ppn   [NUM_ENTRIES];
    logic [LFSR_W-1:0] victim_sr;

    logic [VPN_W-1:0] page_pool [POOL_SIZE];

    int err_count;
    int lookup_count;
    int fill_count;
    int hit_count;
    int checked_count;

    // While calm is set neither side idles, which gives back-to-back
    // stretches between the noisy ones.
    logic        calm;
    int unsigned calm_left;
    int unsigned send_gap;
    int unsigned stall_left;
    tlb_req_t    next_req;
    tlb_rsp_t    exp_rsp;

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Physical page numbers lean toward the two extremes now and then.
    function automatic logic [PPN_W-1:0] pick_ppn();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return PPN_W'($urandom());
    endfunction

    task automatic queue_req(input logic rtype, input logic [VADDR_W-1:0] va,
                             input logic [PPN_W-1:0] pp);
        tlb_req_t item;
        item.req_type = rtype;
        item.vaddr    = va;
        item.new_ppn  = pp;
        pending_reqs.push_back(item);
    endtask

    // Work out the response of one accepted request and update the shadow
    // state the way the block does. A lookup scans the ways of the set in
    // order and stops at the first valid match, so duplicate fills resolve
    // to the lowest way. A fill steps the LFSR first and then overwrites
    // way (LFSR mod ways) without checking for an existing copy.
    task automatic predict_translation(input logic rtype,
                                       input logic [VADDR_W-1:0] va,
                                       input logic [PPN_W-1:0] pp);
        logic [VPN_W-1:0] vpn;
        int unsigned      set_idx;
        int unsigned      slot;
        logic             fb;
        tlb_rsp_t         rsp;
        vpn     = va[VADDR_W-1:PAGE_BITS];
        set_idx = vpn % NUM_SETS;
        rsp     = '0;
        if (rtype == REQ_LOOKUP)
        begin
            lookup_count++;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                slot = set_idx * NUM_WAYS + w;
                if (!rsp.hit && shadow_valid[slot] && shadow_tag[slot] == vpn)
                begin
                    rsp.hit = 1'b1;
                    rsp.ppn = shadow_ppn[slot];
                end
            end
            if (rsp.hit)
                hit_count++;
        end
        else
        begin
            fill_count++;
            // Fibonacci step: taps at bits 0, 2, 3 and 5 feed bit 15.
            fb        = victim_sr[0] ^ victim_sr[2] ^ victim_sr[3] ^ victim_sr[5];
            victim_sr = {fb, victim_sr[LFSR_W-1:1]};
            slot      = set_idx * NUM_WAYS + (victim_sr % NUM_WAYS);
            shadow_valid[slot] = 1'b1;
            shadow_tag[slot]   = vpn;
            shadow_ppn[slot]   = pp;
        end
        expected_rsps.push_back(rsp);
    endtask

    // Random mix. Most beats touch the page pool with a random page offset,
    // so lookups find filled pages and fills keep evicting. The rest is
    // noise: fully random addresses that almost always miss.
    task automatic build_random_traffic();
        int unsigned r;
        logic [VPN_W-1:0] vpn;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            page_pool[i] = VPN_W'($urandom());
            // Spread the pool evenly over the sets.
            page_pool[i][2:0] = 3'(i % NUM_SETS);
        end
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            r   = $urandom_range(0, 99);
            vpn = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 40)
                queue_req(REQ_FILL, {vpn, 12'($urandom())}, pick_ppn());
            else if (r < 85)
                queue_req(REQ_LOOKUP, {vpn, 12'($urandom())}, pick_ppn());
            else
                queue_req(($urandom_range(0, 1) == 1) ? REQ_FILL : REQ_LOOKUP,
                          VADDR_W'($urandom()), pick_ppn());
        end
    endtask

    // Alternate calm and noisy stretches of random length.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calm      <= 1'b0;
            calm_left <= 0;
        end
        else if (calm_left == 0)
        begin
            calm      <= ~calm;
            calm_left <= $urandom_range(50, 400);
        end
        else
        begin
            calm_left <= calm_left - 1;
        end
    end

    // Request driver. The payload only changes when the channel is free,
    // i.e. nothing is offered or the offered beat is taken at this edge.
    // The accepted beat is handed to the predictor at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= REQ_LOOKUP;
            req_ch.vaddr    <= '0;
            req_ch.new_ppn  <= '0;
            send_gap        <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
                predict_translation(req_ch.req_type, req_ch.vaddr, req_ch.new_ppn);
            if (send_gap != 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                next_req         = pending_reqs.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= next_req.req_type;
                req_ch.vaddr    <= next_req.vaddr;
                req_ch.new_ppn  <= next_req.new_ppn;
                // The gap is spent after this beat has been accepted.
                send_gap        <= calm ? 0 : idle_len();
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor. Every accepted response beat is matched against the
    // oldest prediction; ready is dropped at random regardless of valid so
    // that stalls land both on waiting and on idle responses.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected response beat, expected none, got hit=%0b ppn=%05h",
                             $time, rsp_ch.hit, rsp_ch.ppn_out);
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    checked_count++;
                    if (rsp_ch.hit !== exp_rsp.hit)
                    begin
                        err_count++;
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, exp_rsp.hit, rsp_ch.hit);
                    end
                    if (rsp_ch.ppn_out !== exp_rsp.ppn)
                    begin
                        err_count++;
                        $display("%0t: ppn_out mismatch, expected %05h, got %05h",
                                 $time, exp_rsp.ppn, rsp_ch.ppn_out);
                    end
                end
            end
            if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left <= idle_len();
            end
        end
    end

    // Main sequence: reset, directed beats, random beats, drain, verdict.
    initial
    begin
        rst_n          = 1'b0;
        err_count       = 0;
        lookup_count    = 0;
        fill_count      = 0;
        hit_count       = 0;
        checked_count   = 0;
        victim_sr       = LFSR_SEED;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i]   = '0;
            shadow_ppn[i]   = '0;
        end

        // Page 0 matches the zero tag of every shadow entry, but nothing is
        // valid yet, so both lookups must miss.
        queue_req(REQ_LOOKUP, 32'h0000_0000, 20'h00000);
        queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF);
        // Extremes of address and page number; the page offset is ignored.
        queue_req(REQ_FILL,   32'h0000_0000, 20'hFFFFF);
        queue_req(REQ_LOOKUP, 32'h0000_0FFF, 20'h00000);
        queue_req(REQ_FILL,   32'hFFFF_FFFF, 20'h00000);
        queue_req(REQ_LOOKUP, 32'hFFFF_F000, 20'h00000);
        // new_ppn on a lookup has no effect.
        queue_req(REQ_LOOKUP, 32'h0000_0123, 20'h12345);
        // Same page filled again and again: several ways end up with the
        // same tag and the lookup must report the lowest of them.
        queue_req(REQ_FILL,   32'h0001_0000, 20'hAAAAA);
        queue_req(REQ_FILL,   32'h0001_0ABC, 20'h55555);
        queue_req(REQ_FILL,   32'h0001_0000, 20'h0F0F0);
        queue_req(REQ_FILL,   32'h0001_0FFF, 20'hF0F0F);
        queue_req(REQ_LOOKUP, 32'h0001_0000, 20'h00000);
        // Page 0 shares set 0 and may have been evicted by now.
        queue_req(REQ_LOOKUP, 32'h0000_0000, 20'h00000);
        // Same set, tag never filled: a miss.
        queue_req(REQ_LOOKUP, 32'h0000_8000, 20'h00000);
        // Sets 1 and 2 hold nothing of the above; then a fill and lookup in set 7.
        queue_req(REQ_FILL,   32'h0000_1000, 20'h00001);
        queue_req(REQ_LOOKUP, 32'h0000_1000, 20'h00000);
        queue_req(REQ_LOOKUP, 32'h0000_2000, 20'h00000);
        queue_req(REQ_FILL,   32'h8000_7000, 20'h80000);
        queue_req(REQ_LOOKUP, 32'h8000_7FFF, 20'h00000);

        build_random_traffic();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d lookups (%0d hits) and %0d fills over %0d checked beats.",
                 lookup_count, hit_count, fill_count, checked_count);
        if (err_count == 0)
            $display("tb_set_assoc_tlb_random_replace_core: PASS");
        else
            $display("tb_set_assoc_tlb_random_replace_core: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every gap and stall
    // at its longest.
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d requests unsent and %0d responses outstanding.",
                 pending_reqs.size(), expected_rsps.size());
        $display("tb_set_assoc_tlb_random_replace_core: FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/satlb_pkg.sv
rtl/core/satlb_if.sv
rtl/core/satlb_ram.sv
rtl/core/satlb_cmod.sv
rtl/core/set_assoc_tlb_random_replace_core.sv
tb/sv/tb_set_assoc_tlb_random_replace_core.sv
